@@ src/imh_pkg.sv @@
// Package for the indexed min-heap open list: op codes, default sizes and widths.
// No dependencies.
package imh_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int COST_BITS_DEF = 24;
    localparam int COORD_W       = 16;

    localparam logic [2:0] OP_PUSH     = 3'd0;
    localparam logic [2:0] OP_POP      = 3'd1;
    localparam logic [2:0] OP_FIND     = 3'd2;
    localparam logic [2:0] OP_DECREASE = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

endpackage

@@ src/imh_mem.sv @@
// Heap entry store: one write port, one registered read port.
// Depends on imh_pkg.
module imh_mem
    import imh_pkg::*;
#(
    parameter int DEPTH  = CAPACITY_DEF,
    parameter int WIDTH  = 128
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/indexed_min_heap_open_list.sv @@
// Indexed binary min-heap open list: a small sequencer over one entry memory
// and one shared key compare. Clear, errors, bad positions and unused ops go
// straight to the result; push and decrease (after reading the entry) sift up,
// one parent per step; pop reads root then last, then sifts down, reading both
// children of a level when there is a left child; find reads entries in order.
// All reads use the single registered memory port; the next word is taken in the
// cycle after the result goes. Reset empties the heap.
module indexed_min_heap_open_list
    import imh_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int COST_BITS = COST_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  op,
    input  logic signed [15:0]          coord_x,
    input  logic signed [15:0]          coord_z,
    input  logic [COST_BITS-1:0]        cost_g,
    input  logic [COST_BITS-1:0]        cost_h,
    input  logic signed [15:0]          prev_x,
    input  logic signed [15:0]          prev_z,
    input  logic [$clog2(CAPACITY)-1:0] position,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [$clog2(CAPACITY):0]   found_position,
    output logic signed [15:0]          out_x,
    output logic signed [15:0]          out_z,
    output logic [COST_BITS-1:0]        out_g,
    output logic [COST_BITS-1:0]        out_h,
    output logic signed [15:0]          out_prev_x,
    output logic signed [15:0]          out_prev_z,
    output logic [$clog2(CAPACITY):0]   entry_count,
    output logic                        error
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam int EW = 4 * COORD_W + 2 * COST_BITS;
    localparam int KW = COST_BITS + 1;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    // entry layout: x z g h px pz
    typedef struct packed {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   z;
        logic [COST_BITS-1:0] g;
        logic [COST_BITS-1:0] h;
        logic [COORD_W-1:0]   px;
        logic [COORD_W-1:0]   pz;
    } entry_t;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0, S_FIND_WT = 4'd1, S_FIND = 4'd2,
        S_DEC_RD = 4'd3, S_DEC_WT = 4'd4, S_UP_RD = 4'd5, S_UP_CMP = 4'd6,
        S_POP_RD = 4'd7, S_POP_LAST = 4'd8, S_POP_GET = 4'd9, S_DN_RDL = 4'd10,
        S_DN_RDR = 4'd11, S_DN_CMP = 4'd12, S_DN_MOVE = 4'd13, S_WB = 4'd14,
        S_OUT = 4'd15;

    logic [3:0]    state_reg;
    logic [CW-1:0] fill_reg;
    logic [AW-1:0] idx_reg;      // hole position of the moving entry
    logic [AW-1:0] pick_reg;     // chosen child position during sift down
    logic [CW-1:0] scan_reg;     // find scan address
    entry_t        cur_reg;      // entry being sifted, also the find key
    entry_t        oth_reg;      // left child, then the chosen child
    entry_t        pop_reg;
    logic          err_reg;
    logic [CW-1:0] found_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;
    logic [EW-1:0] rd_raw;

    imh_mem #(.DEPTH(CAPACITY), .WIDTH(EW)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_raw));
    assign rd_data = entry_t'(rd_raw);

    function automatic logic [KW-1:0] key_f(entry_t e);
        return KW'(e.g) + KW'(e.h);
    endfunction

    // single shared key compare, operands picked by state
    entry_t cmp_a, cmp_b;
    logic   a_lt_b;
    assign a_lt_b = key_f(cmp_a) < key_f(cmp_b);

    always_comb
    begin
        cmp_a = cur_reg;
        cmp_b = rd_data;
        case (state_reg)
            S_DN_CMP:
            begin
                // left child against right child
                cmp_a = oth_reg;
                cmp_b = rd_data;
            end
            S_DN_MOVE:
            begin
                // chosen child against the moving entry
                cmp_a = oth_reg;
                cmp_b = cur_reg;
            end
            default:   ;
        endcase
    end

    // tree addressing
    logic [AW-1:0] parent_idx;
    logic [CW:0]   left_w, right_w, fill_w;
    logic          has_left, right_ok;
    assign parent_idx = (idx_reg - AW'(1)) >> 1;
    assign left_w     = {1'b0, idx_reg, 1'b1};
    assign right_w    = {1'b0, idx_reg, 1'b0} + (CW+1)'(2);
    assign fill_w     = {1'b0, fill_reg};
    assign has_left   = left_w < fill_w;
    assign right_ok   = right_w < fill_w;

    // memory port use per state
    always_comb
    begin
        rd_addr = AW'(scan_reg);
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = cur_reg;
        case (state_reg)
            S_DEC_RD:   rd_addr = idx_reg;
            S_UP_RD:    rd_addr = parent_idx;
            S_UP_CMP:
            begin
                // parent moves down into the hole
                wr_en   = a_lt_b;
                wr_data = rd_data;
            end
            S_POP_RD:   rd_addr = '0;
            S_POP_LAST: rd_addr = AW'(fill_reg - CW'(1));
            S_DN_RDL:   rd_addr = AW'(left_w);
            S_DN_RDR:   rd_addr = AW'(right_w);
            S_DN_MOVE:
            begin
                // chosen child moves up into the hole
                wr_en   = a_lt_b;
                wr_data = oth_reg;
            end
            S_WB:       wr_en = 1'b1;
            default:    ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            pick_reg  <= '0;
            scan_reg  <= '0;
            cur_reg   <= '0;
            oth_reg   <= '0;
            pop_reg   <= '0;
            err_reg   <= 1'b0;
            found_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        err_reg   <= (op == OP_PUSH && fill_reg >= CAP)
                                     || (op == OP_POP && fill_reg == '0);
                        found_reg <= (op == OP_FIND) ? fill_reg : '0;
                        pop_reg   <= '0;
                        cur_reg   <= '{coord_x, coord_z, cost_g, cost_h, prev_x, prev_z};
                        scan_reg  <= '0;
                        case (op)
                            OP_PUSH:
                            begin
                                if (fill_reg >= CAP)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    idx_reg   <= AW'(fill_reg);
                                    fill_reg  <= fill_reg + CW'(1);
                                    state_reg <= (fill_reg == '0) ? S_WB : S_UP_RD;
                                end
                            end
                            OP_POP:    state_reg <= (fill_reg == '0) ? S_OUT : S_POP_RD;
                            OP_FIND:   state_reg <= (fill_reg == '0) ? S_OUT : S_FIND_WT;
                            OP_DECREASE:
                            begin
                                if (CW'(position) < fill_reg)
                                begin
                                    idx_reg   <= position;
                                    state_reg <= S_DEC_RD;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            OP_CLEAR:
                            begin
                                fill_reg  <= '0;
                                state_reg <= S_OUT;
                            end
                            default:   state_reg <= S_OUT;
                        endcase
                    end
                end
                // find: one entry per cycle, read registered
                S_FIND_WT:
                begin
                    scan_reg  <= scan_reg + CW'(1);
                    state_reg <= S_FIND;
                end
                S_FIND:
                begin
                    if (rd_data.x == cur_reg.x && rd_data.z == cur_reg.z)
                    begin
                        found_reg <= scan_reg - CW'(1);
                        state_reg <= S_OUT;
                    end
                    else if (scan_reg >= fill_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + CW'(1);
                    end
                end
                // decrease: keep stored coordinates, take new costs and predecessor
                S_DEC_RD:  state_reg <= S_DEC_WT;
                S_DEC_WT:
                begin
                    cur_reg   <= '{rd_data.x, rd_data.z, cur_reg.g, cur_reg.h,
                                   cur_reg.px, cur_reg.pz};
                    state_reg <= (idx_reg == '0) ? S_WB : S_UP_RD;
                end
                // sift up: hole at idx_reg, cur_reg is the entry
                S_UP_RD:   state_reg <= S_UP_CMP;
                S_UP_CMP:
                begin
                    if (a_lt_b)
                    begin
                        idx_reg   <= parent_idx;
                        state_reg <= (parent_idx == '0) ? S_WB : S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_WB;
                    end
                end
                // pop: read root then last
                S_POP_RD:  state_reg <= S_POP_LAST;
                S_POP_LAST:
                begin
                    pop_reg   <= rd_data;
                    state_reg <= S_POP_GET;
                end
                S_POP_GET:
                begin
                    cur_reg   <= rd_data;
                    fill_reg  <= fill_reg - CW'(1);
                    idx_reg   <= '0;
                    state_reg <= S_DN_RDL;
                end
                // sift down: hole at idx_reg
                S_DN_RDL:  state_reg <= has_left ? S_DN_RDR : S_WB;
                S_DN_RDR:
                begin
                    oth_reg   <= rd_data;   // left child
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    // a tie goes to the right child
                    if (right_ok && !a_lt_b)
                    begin
                        oth_reg  <= rd_data;
                        pick_reg <= AW'(right_w);
                    end
                    else
                    begin
                        pick_reg <= AW'(left_w);
                    end
                    state_reg <= S_DN_MOVE;
                end
                S_DN_MOVE:
                begin
                    if (a_lt_b)
                    begin
                        idx_reg   <= pick_reg;
                        state_reg <= S_DN_RDL;
                    end
                    else
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:      state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall       = state_reg != S_IDLE;
    assign out_valid      = state_reg == S_OUT;
    assign found_position = found_reg;
    assign out_x          = pop_reg.x;
    assign out_z          = pop_reg.z;
    assign out_g          = pop_reg.g;
    assign out_h          = pop_reg.h;
    assign out_prev_x     = pop_reg.px;
    assign out_prev_z     = pop_reg.pz;
    assign entry_count    = fill_reg;
    assign error          = err_reg;

endmodule
